[sv/wrs_pkg.sv]
// Package: shared types, constants and the suite OUI lookup for the WPA/RSN element parser.
`default_nettype none

package wrs_pkg;

  // Element type octets
  localparam logic [7:0] EID_VENDOR = 8'hdd;
  localparam logic [7:0] EID_RSN    = 8'h30;
  localparam logic [7:0] WPA_OUI_TYPE = 8'h01;

  // Shortest WPA vendor element body that can hold OUI, type and version
  localparam logic [7:0] WPA_MIN_LEN = 8'd6;

  // Suite type defaults
  localparam logic [7:0] SUITE_NONE = 8'd0;
  localparam logic [7:0] SUITE_TKIP = 8'd2;

  // Authentication method codes
  localparam logic [1:0] AUTH_OPEN = 2'd0;
  localparam logic [1:0] AUTH_WEP  = 2'd1;
  localparam logic [1:0] AUTH_WPA  = 2'd2;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_WPA   = 2'd1,
    KIND_RSN   = 2'd2
  } kind_e;

  typedef struct packed {
    logic [1:0] auth;
    logic [7:0] group;
    logic [7:0] pairwise;
    logic [7:0] akm;
  } sec_rec_t;

  // Expected OUI octet for a suite field of the given element kind
  function automatic logic [7:0] oui_byte(input kind_e kind, input logic [1:0] idx);
    logic [7:0] res;
    res = 8'h00;
    case (kind)
      KIND_WPA: begin
        case (idx)
          2'd1:    res = 8'h50;
          2'd2:    res = 8'hf2;
          default: res = 8'h00;
        endcase
      end
      KIND_RSN: begin
        case (idx)
          2'd1:    res = 8'h0f;
          2'd2:    res = 8'hac;
          default: res = 8'h00;
        endcase
      end
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/wrs_in_if.sv]
// Interface: input octet channel (valid/ready plus octet, key flag and last marker).
`default_nettype none

interface wrs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ie_byte;
  logic       has_key;
  logic       last_byte;

  modport source (output valid, output ie_byte, output has_key, output last_byte,
                  input ready);
  modport sink   (input valid, input ie_byte, input has_key, input last_byte,
                  output ready);
endinterface

`default_nettype wire

[sv/wrs_out_if.sv]
// Interface: security record channel (valid/ready plus record fields).
`default_nettype none

interface wrs_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] auth_method;
  logic [7:0] group_cipher;
  logic [7:0] pairwise_cipher;
  logic [7:0] key_management;

  modport source (output valid, output auth_method, output group_cipher,
                  output pairwise_cipher, output key_management, input ready);
  modport sink   (input valid, input auth_method, input group_cipher,
                  input pairwise_cipher, input key_management, output ready);
endinterface

`default_nettype wire

[sv/wpa_rsn_ie_security_parser.sv]
// Top level: WPA/RSN information-element parser, one octet per request.
//
//   channel | dir | payload                                        | request
//   --------+-----+------------------------------------------------+----------------------
//   ie_i    | in  | ie_byte, has_key, last_byte                    | one element-list octet
//   rec_o   | out | auth_method, group_cipher, pairwise_cipher,    | one record per list,
//           |     | key_management                                 | on the last octet
//
// Cycles: one octet per clock while ie_i.ready is high; the parse state is updated
// at the edge that takes the octet, and a record appears in the output register
// the cycle after the last octet is taken. The only limit is the single output register.
// Reset: asynchronous, clears the parser to "expecting element type" with no
// list in progress and the output register empty.
// Stalls: ie_i.ready stays high while the output register is empty or being
// drained, so a new octet is taken alongside a record leaving.
`default_nettype none

module wpa_rsn_ie_security_parser (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wrs_in_if.sink    ie_i,
  wrs_out_if.source rec_o
);

  typedef enum logic [3:0] {
    PH_TYPE   = 4'd0,
    PH_LEN    = 4'd1,
    PH_SKIP   = 4'd2,
    PH_WPAHDR = 4'd3,
    PH_VER    = 4'd4,
    PH_GROUP  = 4'd5,
    PH_PCNT   = 4'd6,
    PH_PSUITE = 4'd7,
    PH_ACNT   = 4'd8,
    PH_ASUITE = 4'd9
  } phase_e;

  // Parser state
  phase_e            phase_q, phase_d;
  wrs_pkg::kind_e    kind_q, kind_d;
  logic [8:0]        bie_q, bie_d;        // octet position inside the element
  logic [7:0]        len_q, len_d;        // element length octet
  logic              oui_ok_q, oui_ok_d;  // OUI compare of the current field so far
  logic [15:0]       cnt_q, cnt_d;        // suites left in the current list
  logic [1:0]        sbi_q, sbi_d;        // octet inside the current field
  logic              started_q, started_d;
  wrs_pkg::sec_rec_t rec_q, rec_d;

  // Output register
  logic              out_vld_q;
  wrs_pkg::sec_rec_t out_rec_q;

  logic       take;
  logic [7:0] b;
  logic       hk;
  logic [7:0] oui_exp;
  logic [8:0] elem_end;
  logic [15:0] cnt_full;
  logic [15:0] cnt_dec;
  logic [18:0] list_need;
  logic [18:0] list_limit;
  logic        list_fits;
  wrs_pkg::sec_rec_t rec_start;
  wrs_pkg::sec_rec_t rec_reset;
  wrs_pkg::sec_rec_t rec_secure;
  wrs_pkg::sec_rec_t rec_plain;

  assign ie_i.ready = !out_vld_q || rec_o.ready;
  assign take       = ie_i.valid && ie_i.ready;
  assign b          = ie_i.ie_byte;
  assign hk         = ie_i.has_key;

  assign rec_o.valid           = out_vld_q;
  assign rec_o.auth_method     = out_rec_q.auth;
  assign rec_o.group_cipher    = out_rec_q.group;
  assign rec_o.pairwise_cipher = out_rec_q.pairwise;
  assign rec_o.key_management  = out_rec_q.akm;

  assign rec_start  = '{auth: hk ? wrs_pkg::AUTH_WEP : wrs_pkg::AUTH_OPEN,
                        group: wrs_pkg::SUITE_TKIP, pairwise: wrs_pkg::SUITE_TKIP,
                        akm: wrs_pkg::SUITE_NONE};
  assign rec_reset  = '{auth: wrs_pkg::AUTH_OPEN,
                        group: wrs_pkg::SUITE_TKIP, pairwise: wrs_pkg::SUITE_TKIP,
                        akm: wrs_pkg::SUITE_NONE};
  assign rec_secure = '{auth: wrs_pkg::AUTH_WPA,
                        group: wrs_pkg::SUITE_TKIP, pairwise: wrs_pkg::SUITE_TKIP,
                        akm: wrs_pkg::SUITE_NONE};
  assign rec_plain  = '{auth: hk ? wrs_pkg::AUTH_WEP : wrs_pkg::AUTH_OPEN,
                        group: wrs_pkg::SUITE_NONE, pairwise: wrs_pkg::SUITE_NONE,
                        akm: wrs_pkg::SUITE_NONE};

  assign oui_exp  = wrs_pkg::oui_byte(kind_q, sbi_q);
  assign elem_end = {1'b0, len_q} + 9'd1;

  // Second count octet: does the whole suite list fit inside the element?
  assign cnt_full   = {b, cnt_q[7:0]};
  assign list_need  = {10'b0, bie_q} + 19'd1 + {1'b0, cnt_full, 2'b00};
  assign list_limit = {11'b0, len_q} + 19'd2;
  assign list_fits  = (list_need <= list_limit);
  assign cnt_dec    = cnt_q - 16'd1;

  always_comb begin
    phase_d   = phase_q;
    kind_d    = kind_q;
    bie_d     = bie_q;
    len_d     = len_q;
    oui_ok_d  = oui_ok_q;
    cnt_d     = cnt_q;
    sbi_d     = sbi_q;
    started_d = 1'b1;
    rec_d     = started_q ? rec_q : rec_start;

    case (phase_q)
      PH_TYPE: begin
        if (b == wrs_pkg::EID_VENDOR) begin
          kind_d = wrs_pkg::KIND_WPA;
        end else if (b == wrs_pkg::EID_RSN) begin
          kind_d = wrs_pkg::KIND_RSN;
        end else begin
          kind_d = wrs_pkg::KIND_OTHER;
        end
        bie_d   = 9'd1;
        phase_d = PH_LEN;
      end

      PH_LEN: begin
        len_d    = b;
        sbi_d    = 2'd0;
        oui_ok_d = 1'b1;
        if (kind_q == wrs_pkg::KIND_RSN) begin
          rec_d   = rec_secure;
          phase_d = PH_VER;
        end else if (kind_q == wrs_pkg::KIND_WPA) begin
          if (b < wrs_pkg::WPA_MIN_LEN) begin
            rec_d   = rec_plain;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_WPAHDR;
          end
        end else begin
          phase_d = PH_SKIP;
        end
        bie_d = 9'd2;
        if (b == 8'd0) begin
          phase_d = PH_TYPE;
        end
      end

      default: begin
        // Element body octet
        case (phase_q)
          PH_WPAHDR: begin
            if (sbi_q != 2'd3) begin
              if (b != wrs_pkg::oui_byte(wrs_pkg::KIND_WPA, sbi_q)) oui_ok_d = 1'b0;
              sbi_d = sbi_q + 2'd1;
            end else begin
              sbi_d    = 2'd0;
              oui_ok_d = 1'b1;
              if (oui_ok_q && b == wrs_pkg::WPA_OUI_TYPE) begin
                rec_d   = rec_secure;
                phase_d = PH_VER;
              end else begin
                rec_d   = rec_plain;
                phase_d = PH_SKIP;
              end
            end
          end

          PH_VER: begin
            if (sbi_q == 2'd0) begin
              sbi_d = 2'd1;
            end else begin
              sbi_d    = 2'd0;
              oui_ok_d = 1'b1;
              phase_d  = PH_GROUP;
            end
          end

          PH_GROUP: begin
            if (sbi_q != 2'd3) begin
              if (b != oui_exp) oui_ok_d = 1'b0;
              sbi_d = sbi_q + 2'd1;
            end else begin
              rec_d.group = oui_ok_q ? b : wrs_pkg::SUITE_NONE;
              sbi_d    = 2'd0;
              oui_ok_d = 1'b1;
              phase_d  = PH_PCNT;
            end
          end

          PH_PCNT, PH_ACNT: begin
            if (sbi_q == 2'd0) begin
              cnt_d = {8'd0, b};
              sbi_d = 2'd1;
            end else begin
              cnt_d    = cnt_full;
              sbi_d    = 2'd0;
              oui_ok_d = 1'b1;
              if (!list_fits) begin
                phase_d = PH_SKIP;
              end else if (cnt_full == 16'd0) begin
                phase_d = (phase_q == PH_PCNT) ? PH_ACNT : PH_SKIP;
              end else begin
                phase_d = (phase_q == PH_PCNT) ? PH_PSUITE : PH_ASUITE;
              end
            end
          end

          PH_PSUITE, PH_ASUITE: begin
            if (sbi_q != 2'd3) begin
              if (b != oui_exp) oui_ok_d = 1'b0;
              sbi_d = sbi_q + 2'd1;
            end else begin
              if (oui_ok_q) begin
                if (phase_q == PH_PSUITE) begin
                  rec_d.pairwise = b;
                end else begin
                  rec_d.akm = b;
                end
              end
              cnt_d    = cnt_dec;
              sbi_d    = 2'd0;
              oui_ok_d = 1'b1;
              if (cnt_dec == 16'd0) begin
                phase_d = (phase_q == PH_PSUITE) ? PH_ACNT : PH_SKIP;
              end
            end
          end

          default: ;
        endcase

        // Element boundary overrides whatever the field logic chose
        if (bie_q >= elem_end) begin
          phase_d  = PH_TYPE;
          sbi_d    = 2'd0;
          oui_ok_d = 1'b1;
          bie_d    = 9'd0;
        end else begin
          bie_d = bie_q + 9'd1;
        end
      end
    endcase

    // Last octet: record leaves, parser starts a fresh list
    if (ie_i.last_byte) begin
      phase_d   = PH_TYPE;
      kind_d    = wrs_pkg::KIND_OTHER;
      bie_d     = 9'd0;
      len_d     = 8'd0;
      oui_ok_d  = 1'b1;
      cnt_d     = 16'd0;
      sbi_d     = 2'd0;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_TYPE;
      kind_q    <= wrs_pkg::KIND_OTHER;
      bie_q     <= 9'd0;
      len_q     <= 8'd0;
      oui_ok_q  <= 1'b1;
      cnt_q     <= 16'd0;
      sbi_q     <= 2'd0;
      started_q <= 1'b0;
      rec_q     <= rec_reset;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q   <= phase_d;
        kind_q    <= kind_d;
        bie_q     <= bie_d;
        len_q     <= len_d;
        oui_ok_q  <= oui_ok_d;
        cnt_q     <= cnt_d;
        sbi_q     <= sbi_d;
        started_q <= started_d;
        rec_q     <= ie_i.last_byte ? rec_reset : rec_d;
      end
      if (take && ie_i.last_byte) begin
        out_vld_q <= 1'b1;
      end else if (rec_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Record payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (take && ie_i.last_byte) begin
      out_rec_q <= rec_d;
    end
  end

endmodule

`default_nettype wire

[tb/wrs_checker.sv]
// Checker: predicts the security record of each element list and compares it with the block.
module wrs_checker
  import wrs_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  wrs_in_if    ie_ch,
  wrs_out_if   rec_ch,
  output int   fails_o,
  output int   pending_o
);

  localparam logic [23:0] WPA_OUI = 24'h0050f2;
  localparam logic [23:0] RSN_OUI = 24'h000fac;

  typedef enum logic [3:0] {
    FLD_TYPE, FLD_LEN, FLD_SKIP, FLD_WPAHDR, FLD_VER, FLD_GROUP,
    FLD_PCNT, FLD_PSUITE, FLD_ACNT, FLD_ASUITE
  } field_e;

  // parser copy
  logic [8:0]  pos;
  logic [7:0]  elem_len;
  kind_e       kind;
  field_e      fld;
  logic        oui_ok;
  logic [15:0] suites_left;
  logic [1:0]  fidx;
  sec_rec_t    rec;
  logic        in_list;

  sec_rec_t records_due[$];
  int       mism;
  int       shown;

  assign fails_o = mism;

  function automatic logic [7:0] suite_oui(input kind_e k, input logic [1:0] idx);
    logic [23:0] oui;
    oui = (k == KIND_RSN) ? RSN_OUI : (k == KIND_WPA) ? WPA_OUI : 24'h0;
    return oui[23 - 8 * idx -: 8];
  endfunction

  task automatic clear_parser();
    pos          = '0;
    elem_len     = '0;
    kind         = KIND_OTHER;
    fld          = FLD_TYPE;
    oui_ok       = 1'b1;
    suites_left  = '0;
    fidx         = '0;
    rec.auth     = AUTH_OPEN;
    rec.group    = SUITE_TKIP;
    rec.pairwise = SUITE_TKIP;
    rec.akm      = SUITE_NONE;
    in_list      = 1'b0;
  endtask

  task automatic secure_defaults();
    rec.auth     = AUTH_WPA;
    rec.group    = SUITE_TKIP;
    rec.pairwise = SUITE_TKIP;
    rec.akm      = SUITE_NONE;
  endtask

  task automatic plain_record(input logic hk);
    rec.auth     = hk ? AUTH_WEP : AUTH_OPEN;
    rec.group    = SUITE_NONE;
    rec.pairwise = SUITE_NONE;
    rec.akm      = SUITE_NONE;
  endtask

  task automatic begin_field(input field_e f);
    fld    = f;
    fidx   = '0;
    oui_ok = 1'b1;
  endtask

  // one body octet of a WPA or RSN element
  task automatic body_octet(input logic [7:0] b, input logic hk);
    int first_free;
    case (fld)
      FLD_WPAHDR: begin
        if (fidx < 2'd3) begin
          if (b != suite_oui(KIND_WPA, fidx)) oui_ok = 1'b0;
          fidx = fidx + 2'd1;
        end else if (oui_ok && b == WPA_OUI_TYPE) begin
          secure_defaults();
          begin_field(FLD_VER);
        end else begin
          plain_record(hk);
          begin_field(FLD_SKIP);
        end
      end
      FLD_VER: begin
        if (fidx == 2'd0) fidx = 2'd1;
        else begin_field(FLD_GROUP);
      end
      FLD_GROUP: begin
        if (fidx < 2'd3) begin
          if (b != suite_oui(kind, fidx)) oui_ok = 1'b0;
          fidx = fidx + 2'd1;
        end else begin
          rec.group = oui_ok ? b : SUITE_NONE;
          begin_field(FLD_PCNT);
        end
      end
      FLD_PCNT, FLD_ACNT: begin
        if (fidx == 2'd0) begin
          suites_left = {8'h00, b};
          fidx = 2'd1;
        end else begin
          suites_left[15:8] = b;
          // whole list must sit inside the element
          first_free = int'(pos) + 1 + 4 * int'(suites_left);
          if (first_free > int'(elem_len) + 2) begin_field(FLD_SKIP);
          else if (suites_left == 16'd0) begin_field(fld == FLD_PCNT ? FLD_ACNT : FLD_SKIP);
          else begin_field(fld == FLD_PCNT ? FLD_PSUITE : FLD_ASUITE);
        end
      end
      FLD_PSUITE, FLD_ASUITE: begin
        if (fidx < 2'd3) begin
          if (b != suite_oui(kind, fidx)) oui_ok = 1'b0;
          fidx = fidx + 2'd1;
        end else begin
          if (oui_ok) begin
            if (fld == FLD_PSUITE) rec.pairwise = b;
            else rec.akm = b;
          end
          suites_left = suites_left - 16'd1;
          begin_field(fld);
          if (suites_left == 16'd0) begin_field(fld == FLD_PSUITE ? FLD_ACNT : FLD_SKIP);
        end
      end
      default: ;
    endcase
  endtask

  task automatic take_octet(input logic [7:0] b, input logic hk, input logic last);
    if (!in_list) begin
      rec.auth     = hk ? AUTH_WEP : AUTH_OPEN;
      rec.group    = SUITE_TKIP;
      rec.pairwise = SUITE_TKIP;
      rec.akm      = SUITE_NONE;
      in_list      = 1'b1;
    end
    if (fld == FLD_TYPE) begin
      kind = (b == EID_VENDOR) ? KIND_WPA : (b == EID_RSN) ? KIND_RSN : KIND_OTHER;
      pos  = 9'd1;
      fld  = FLD_LEN;
    end else if (fld == FLD_LEN) begin
      elem_len = b;
      if (kind == KIND_RSN) begin
        secure_defaults();
        begin_field(FLD_VER);
      end else if (kind == KIND_WPA) begin
        if (b < WPA_MIN_LEN) begin
          begin_field(FLD_SKIP);
          plain_record(hk);
        end else begin
          begin_field(FLD_WPAHDR);
        end
      end else begin
        begin_field(FLD_SKIP);
      end
      pos = 9'd2;
      if (elem_len == 8'd0) begin_field(FLD_TYPE);
    end else begin
      body_octet(b, hk);
      if (pos >= elem_len + 1) begin
        begin_field(FLD_TYPE);
        pos = '0;
      end else begin
        pos = pos + 9'd1;
      end
    end
    if (last) begin
      records_due.push_back(rec);
      clear_parser();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sec_rec_t got, want;
    if (!rst_ni) begin
      clear_parser();
      records_due.delete();
      mism      = 0;
      shown     = 0;
      pending_o <= 0;
    end else begin
      // result side first: a record never leaves on the edge its last octet enters
      if (rec_ch.valid === 1'b1 && rec_ch.ready === 1'b1) begin
        got = {rec_ch.auth_method, rec_ch.group_cipher, rec_ch.pairwise_cipher,
               rec_ch.key_management};
        if (records_due.size() == 0) begin
          mism++;
          if (shown < 10) begin
            shown++;
            $display("unexpected record: auth %0d grp %0d pw %0d akm %0d",
                     got.auth, got.group, got.pairwise, got.akm);
          end
        end else begin
          want = records_due.pop_front();
          if (got.auth !== want.auth || got.group !== want.group ||
              got.pairwise !== want.pairwise || got.akm !== want.akm) begin
            mism++;
            if (shown < 10) begin
              shown++;
              $display({"record mismatch: exp auth %0d grp %0d pw %0d akm %0d, ",
                        "got auth %0d grp %0d pw %0d akm %0d"},
                       want.auth, want.group, want.pairwise, want.akm,
                       got.auth, got.group, got.pairwise, got.akm);
            end
          end
        end
      end
      if (ie_ch.valid === 1'b1 && ie_ch.ready === 1'b1)
        take_octet(ie_ch.ie_byte, ie_ch.has_key, ie_ch.last_byte);
      pending_o <= records_due.size();
    end
  end

endmodule

[tb/tb.sv]
// Testbench top: element-list stimulus, receiver back-pressure and the verdict.
module tb;
  import wrs_pkg::*;

  localparam logic [23:0] WPA_OUI     = 24'h0050f2;
  localparam logic [23:0] RSN_OUI     = 24'h000fac;
  localparam int          HOLD_CYCLES = 200;  // long receiver hold-off
  localparam int          PHASE_OCTS  = 480;  // octets per idling phase

  logic clk_i = 1'b0;
  logic rst_ni;

  wrs_in_if  ie_if ();
  wrs_out_if rec_if ();

  int fails;
  int pending;

  // idling knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;

  // hold-off requests from the stimulus, served by the receiver process
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int octets_sent = 0;
  int lists_sent  = 0;

  logic [7:0] oct_q[$];   // octets of the list being built
  logic [7:0] body_q[$];  // body of the element being built

  wpa_rsn_ie_security_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ie_i   (ie_if),
    .rec_o  (rec_if)
  );

  wrs_checker u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ie_ch     (ie_if),
    .rec_ch    (rec_if),
    .fails_o   (fails),
    .pending_o (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Receiver. A pending hold-off request wins over random stalls and is
  // counted down here, cycle by cycle, while the sender keeps offering.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rec_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rec_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen    <= hold_reqs;
      hold_left    <= HOLD_CYCLES;
      rec_if.ready <= 1'b0;
    end else begin
      rec_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // One suite: OUI (now and then corrupted in one octet) and a type octet,
  // half the time a small familiar code.
  task automatic push_suite(input kind_e k);
    logic [23:0] oui;
    oui = (k == KIND_WPA) ? WPA_OUI : RSN_OUI;
    if ($urandom_range(9) == 0) oui[8 * $urandom_range(2) +: 8] = 8'($urandom);
    body_q.push_back(oui[23:16]);
    body_q.push_back(oui[15:8]);
    body_q.push_back(oui[7:0]);
    body_q.push_back(($urandom_range(1) == 0) ? 8'($urandom_range(15)) : 8'($urandom));
  endtask

  // Little-endian count and its suites. Mostly 0..3; sometimes 0xffff, which can
  // never fit in the element, or a random 16-bit count.
  task automatic push_suite_list(input kind_e k);
    logic [15:0] cnt;
    int          n;
    case ($urandom_range(19))
      0:       cnt = 16'hffff;
      1:       cnt = 16'($urandom);
      default: cnt = 16'($urandom_range(3));
    endcase
    n = (cnt <= 16'd3) ? int'(cnt) : $urandom_range(3);
    body_q.push_back(cnt[7:0]);
    body_q.push_back(cnt[15:8]);
    repeat (n) push_suite(k);
  endtask

  // WPA vendor element or RSN element. The body is mostly well formed so the
  // parser gets deep into the suite lists; the length octet is sometimes
  // wrong, which gives short WPA headers, lists beyond the element and
  // misaligned element walks.
  task automatic add_secure_element(input kind_e k);
    logic [31:0] hdr;
    int          len;
    body_q.delete();
    if (k == KIND_WPA) begin
      hdr = {WPA_OUI, WPA_OUI_TYPE};
      if ($urandom_range(9) == 0) hdr[8 * $urandom_range(3) +: 8] = 8'($urandom);
      for (int i = 3; i >= 0; i--) body_q.push_back(hdr[8 * i +: 8]);
    end
    body_q.push_back(($urandom_range(15) == 0) ? 8'($urandom) : 8'h01);
    body_q.push_back(8'h00);
    if ($urandom_range(7) != 0) begin
      push_suite(k);
      if ($urandom_range(7) != 0) begin
        push_suite_list(k);
        if ($urandom_range(5) != 0) push_suite_list(k);
      end
    end
    // capabilities and the like, ignored by the parser
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0)
      body_q.push_back(8'($urandom));
    len = body_q.size();
    if ($urandom_range(6) == 0) len = $urandom_range(len + 4);
    if (len > 255) len = 255;
    oct_q.push_back((k == KIND_WPA) ? EID_VENDOR : EID_RSN);
    oct_q.push_back(8'(len));
    foreach (body_q[i]) oct_q.push_back(body_q[i]);
  endtask

  // Any other element: random id and body, rarely a long one.
  task automatic add_plain_element();
    int len;
    len = ($urandom_range(24) == 0) ? $urandom_range(100, 255) : $urandom_range(10);
    oct_q.push_back(8'($urandom));
    oct_q.push_back(8'(len));
    repeat (len) oct_q.push_back(8'($urandom));
  endtask

  // A list of one to four elements; some lists are pure noise, some are cut
  // short by the last marker, some carry trailing junk.
  task automatic build_list();
    int cut;
    oct_q.delete();
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: add_secure_element(KIND_RSN);
        4, 5, 6:    add_secure_element(KIND_WPA);
        default:    add_plain_element();
      endcase
    end
    case ($urandom_range(19))
      0, 1: begin
        oct_q.delete();
        repeat ($urandom_range(1, 24)) oct_q.push_back(8'($urandom));
      end
      2, 3, 4: begin
        cut = $urandom_range(1, oct_q.size());
        while (oct_q.size() > cut) void'(oct_q.pop_back());
      end
      5:       repeat ($urandom_range(1, 3)) oct_q.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // One octet request: optional idle cycles, then hold valid until taken.
  task automatic send_octet(input logic [7:0] b, input logic hk, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      ie_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    ie_if.valid     <= 1'b1;
    ie_if.ie_byte   <= b;
    ie_if.has_key   <= hk;
    ie_if.last_byte <= last;
    @(posedge clk_i);
    while (ie_if.ready !== 1'b1) @(posedge clk_i);
    octets_sent++;
  endtask

  // Sends oct_q with the last marker on its final octet. With key_noise the
  // key flag flips on random octets although it should hold over a list.
  task automatic send_list(input logic hk, input bit key_noise);
    logic kb;
    for (int i = 0; i < oct_q.size(); i++) begin
      kb = (key_noise && $urandom_range(7) == 0) ? ~hk : hk;
      send_octet(oct_q[i], kb, i == oct_q.size() - 1);
    end
    lists_sent++;
  endtask

  // Sender stops and waits for every outstanding record. The first edge lets
  // the checker account for a request taken on the edge just gone.
  task automatic wait_drained();
    ie_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int mark;
    rst_ni           <= 1'b0;
    ie_if.valid      <= 1'b0;
    ie_if.ie_byte    <= 8'h00;
    ie_if.has_key    <= 1'b0;
    ie_if.last_byte  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lists.
    // lone type octet at list end: record is just the key flag
    oct_q = '{EID_RSN};
    send_list(1'b1, 1'b0);
    // WPA vendor element of length zero, too short: plain record, open
    oct_q = '{EID_VENDOR, 8'h00};
    send_list(1'b0, 1'b0);
    // RSN with a foreign group OUI, pairwise count of 0xffff that overruns
    // the element, element cut short by the list end
    oct_q = '{EID_RSN, 8'h0c, 8'h01, 8'h00, 8'h00, 8'h50, 8'hf2, 8'h04,
              8'hff, 8'hff, 8'haa, 8'h55};
    send_list(1'b1, 1'b0);
    // minimal matching WPA header, ends after the version
    oct_q = '{EID_VENDOR, WPA_MIN_LEN, 8'h00, 8'h50, 8'hf2, WPA_OUI_TYPE,
              8'h01, 8'h00};
    send_list(1'b0, 1'b0);
    // short WPA element with key: WEP
    oct_q = '{EID_VENDOR, 8'h02, 8'hff, 8'h00};
    send_list(1'b1, 1'b0);
    wait_drained();

    // Long receiver hold-off while short lists keep coming: the output
    // register fills and the input request stalls.
    hold_reqs++;
    repeat (6) begin
      oct_q.delete();
      repeat ($urandom_range(1, 3)) oct_q.push_back(8'($urandom));
      send_list(1'($urandom_range(1)), 1'b0);
    end
    wait_drained();

    // Random lists over the idling phases; each phase ends fully drained.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 76; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      mark = octets_sent;
      while (octets_sent - mark < PHASE_OCTS || (ph == 3 && lists_sent < 60)) begin
        build_list();
        send_list(1'($urandom_range(1)), $urandom_range(9) == 0);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fails == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end

endmodule

[files.f]
sv/wrs_pkg.sv
sv/wrs_in_if.sv
sv/wrs_out_if.sv
sv/wpa_rsn_ie_security_parser.sv
tb/wrs_checker.sv
tb/tb.sv
